@@ design/led_matrix_chain_frame_driver_macros.svh @@
// Assertion helpers shared by the frame driver modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef LED_MATRIX_CHAIN_FRAME_DRIVER_MACROS_SVH
`define LED_MATRIX_CHAIN_FRAME_DRIVER_MACROS_SVH

// Same-cycle implication
`define LMCFD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define LMCFD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/lmcfd_pkg.sv @@
`default_nettype none

package lmcfd_pkg;

	// Store geometry
	localparam int MAX_DISPLAYS = 8;
	localparam int MOD_W        = 3;
	localparam int ROW_W        = 3;
	localparam int ADDR_W       = MOD_W + ROW_W;
	localparam int MEM_DEPTH    = MAX_DISPLAYS * 8;
	localparam int CNT_W        = 4;
	localparam int TILE_W       = 7;
	localparam int PROD_W       = 8;

	localparam logic [CNT_W-1:0]  MAX_DISP_CNT  = CNT_W'(MAX_DISPLAYS);
	localparam logic [PROD_W-1:0] MAX_DISP_PROD = PROD_W'(MAX_DISPLAYS);
	localparam logic [TILE_W-1:0] MAX_DISP_TILE = TILE_W'(MAX_DISPLAYS);
	localparam logic [ROW_W-1:0]  ROW_LAST      = '1;

	// Configuration bus
	localparam int PADDR_W = 4;
	localparam logic [1:0] CFG_TILES_WIDE  = 2'd0;
	localparam logic [1:0] CFG_TILES_HIGH  = 2'd1;
	localparam logic [1:0] CFG_DISPLAY_MAP = 2'd2;

	localparam logic [3:0]  TILES_WIDE_RST  = 4'd4;
	localparam logic [3:0]  TILES_HIGH_RST  = 4'd2;
	localparam logic [23:0] DISPLAY_MAP_RST = 24'hFAC688;

	// Request commands
	localparam logic [2:0] CMD_SET_PIXEL = 3'd0;
	localparam logic [2:0] CMD_WRITE_ROW = 3'd1;
	localparam logic [2:0] CMD_SHOW      = 3'd2;
	localparam logic [2:0] CMD_START     = 3'd3;
	localparam logic [2:0] CMD_BRIGHT    = 3'd4;

	// Device register addresses
	localparam logic [3:0] REG_ROW0      = 4'd1;
	localparam logic [3:0] REG_DECODE    = 4'd9;
	localparam logic [3:0] REG_INTENSITY = 4'd10;
	localparam logic [3:0] REG_SCAN      = 4'd11;
	localparam logic [3:0] REG_SHUTDOWN  = 4'd12;
	localparam logic [3:0] REG_TEST      = 4'd15;
	localparam logic [7:0] SCAN_ALL_ROWS = 8'd7;
	localparam logic [7:0] DATA_ZERO     = 8'd0;
	localparam logic [7:0] DATA_WAKE     = 8'd1;

	typedef struct packed {
		logic [2:0] cmd;
		logic [5:0] x;
		logic [5:0] y;
		logic       pixel_on;
		logic [2:0] display_slot;
		logic [2:0] row;
		logic [7:0] row_bits;
		logic [7:0] brightness;
	} req_t;

	typedef struct packed {
		logic [3:0] word_cmd;
		logic [7:0] word_data;
		logic       frame_end;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [3:0]  tiles_wide;
		logic [3:0]  tiles_high;
		logic [23:0] display_map;
	} cfg_t;

	// Datapath operations
	typedef enum logic [2:0] {
		OP_NOP,
		OP_PIX_RD,
		OP_PIX_WR,
		OP_ROW_WR,
		OP_EMIT_MEM,
		OP_EMIT_CONST
	} op_t;

	// Sequencer branch conditions
	typedef enum logic [1:0] {
		CN_DISPATCH,
		CN_NEXT,
		CN_LOOP_D,
		CN_LOOP_DR
	} cond_t;

	// Program steps
	typedef logic [3:0] step_t;
	localparam step_t ST_IDLE      = 4'd0;
	localparam step_t ST_PX_RD     = 4'd1;
	localparam step_t ST_PX_WR     = 4'd2;
	localparam step_t ST_ROW_WR    = 4'd3;
	localparam step_t ST_SHOW      = 4'd4;
	localparam step_t ST_INIT_SD   = 4'd5;
	localparam step_t ST_INIT_TEST = 4'd6;
	localparam step_t ST_INIT_SCAN = 4'd7;
	localparam step_t ST_INIT_DEC  = 4'd8;
	localparam step_t ST_INIT_WAKE = 4'd9;
	localparam step_t ST_BRIGHT    = 4'd10;

	typedef struct packed {
		op_t        op;
		cond_t      cond;
		logic [3:0] word_cmd;
		logic [7:0] word_data;
		logic       use_bright;
		logic       last_frame;
		step_t      next;
	} uword_t;

	// Control handed from the sequencer to the datapath
	typedef struct packed {
		op_t              op;
		logic [3:0]       word_cmd;
		logic [7:0]       word_data;
		logic             use_bright;
		logic             frame_end;
		logic             last;
		logic [ROW_W-1:0] row;
		logic [MOD_W-1:0] mod_idx;
	} dp_ctl_t;

	function automatic uword_t mk_uw(input op_t op, input cond_t cond,
		input logic [3:0] wc, input logic [7:0] wd, input logic ub,
		input logic lf, input step_t nx);
		uword_t w;
		w.op         = op;
		w.cond       = cond;
		w.word_cmd   = wc;
		w.word_data  = wd;
		w.use_bright = ub;
		w.last_frame = lf;
		w.next       = nx;
		return w;
	endfunction

	// Control store
	function automatic uword_t ucode_rom(input step_t s);
		uword_t w;
		unique case (s)
			ST_IDLE:      w = mk_uw(OP_NOP, CN_DISPATCH, 4'd0, DATA_ZERO, 1'b0, 1'b0, ST_IDLE);
			ST_PX_RD:     w = mk_uw(OP_PIX_RD, CN_NEXT, 4'd0, DATA_ZERO, 1'b0, 1'b0, ST_PX_WR);
			ST_PX_WR:     w = mk_uw(OP_PIX_WR, CN_NEXT, 4'd0, DATA_ZERO, 1'b0, 1'b0, ST_IDLE);
			ST_ROW_WR:    w = mk_uw(OP_ROW_WR, CN_NEXT, 4'd0, DATA_ZERO, 1'b0, 1'b0, ST_IDLE);
			ST_SHOW:      w = mk_uw(OP_EMIT_MEM, CN_LOOP_DR, REG_ROW0, DATA_ZERO, 1'b0, 1'b1,
				ST_IDLE);
			ST_INIT_SD:   w = mk_uw(OP_EMIT_CONST, CN_LOOP_D, REG_SHUTDOWN, DATA_ZERO, 1'b0,
				1'b0, ST_INIT_TEST);
			ST_INIT_TEST: w = mk_uw(OP_EMIT_CONST, CN_LOOP_D, REG_TEST, DATA_ZERO, 1'b0,
				1'b0, ST_INIT_SCAN);
			ST_INIT_SCAN: w = mk_uw(OP_EMIT_CONST, CN_LOOP_D, REG_SCAN, SCAN_ALL_ROWS, 1'b0,
				1'b0, ST_INIT_DEC);
			ST_INIT_DEC:  w = mk_uw(OP_EMIT_CONST, CN_LOOP_D, REG_DECODE, DATA_ZERO, 1'b0,
				1'b0, ST_INIT_WAKE);
			ST_INIT_WAKE: w = mk_uw(OP_EMIT_CONST, CN_LOOP_D, REG_SHUTDOWN, DATA_WAKE, 1'b0,
				1'b1, ST_IDLE);
			ST_BRIGHT:    w = mk_uw(OP_EMIT_CONST, CN_LOOP_D, REG_INTENSITY, DATA_ZERO, 1'b1,
				1'b1, ST_IDLE);
			default:      w = mk_uw(OP_NOP, CN_NEXT, 4'd0, DATA_ZERO, 1'b0, 1'b0, ST_IDLE);
		endcase
		return w;
	endfunction

	// Entry step for each command; unused codes stay idle
	function automatic step_t dispatch(input logic [2:0] cmd);
		step_t s;
		unique case (cmd)
			CMD_SET_PIXEL: s = ST_PX_RD;
			CMD_WRITE_ROW: s = ST_ROW_WR;
			CMD_SHOW:      s = ST_SHOW;
			CMD_START:     s = ST_INIT_SD;
			CMD_BRIGHT:    s = ST_BRIGHT;
			default:       s = ST_IDLE;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

@@ design/lmcfd_cfg.sv @@
`default_nettype none

module lmcfd_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lmcfd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output lmcfd_pkg::cfg_t                    cfg
);

	logic [3:0]  tiles_wide_q;
	logic [3:0]  tiles_high_q;
	logic [23:0] display_map_q;
	logic        wr_en;
	logic [1:0]  reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];

	// Hold the registers; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiles_wide_q  <= lmcfd_pkg::TILES_WIDE_RST;
			tiles_high_q  <= lmcfd_pkg::TILES_HIGH_RST;
			display_map_q <= lmcfd_pkg::DISPLAY_MAP_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				lmcfd_pkg::CFG_TILES_WIDE:  tiles_wide_q  <= pwdata[3:0];
				lmcfd_pkg::CFG_TILES_HIGH:  tiles_high_q  <= pwdata[3:0];
				lmcfd_pkg::CFG_DISPLAY_MAP: display_map_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_sel)
			lmcfd_pkg::CFG_TILES_WIDE:  prdata = {28'd0, tiles_wide_q};
			lmcfd_pkg::CFG_TILES_HIGH:  prdata = {28'd0, tiles_high_q};
			lmcfd_pkg::CFG_DISPLAY_MAP: prdata = {8'd0, display_map_q};
			default:                    prdata = 32'd0;
		endcase
	end

	assign cfg.tiles_wide  = tiles_wide_q;
	assign cfg.tiles_high  = tiles_high_q;
	assign cfg.display_map = display_map_q;

endmodule

`default_nettype wire

@@ design/lmcfd_seq.sv @@
`default_nettype none
`include "led_matrix_chain_frame_driver_macros.svh"

module lmcfd_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire lmcfd_pkg::req_t     req,
	input  wire lmcfd_pkg::cfg_t     cfg,
	output logic                     busy,
	output lmcfd_pkg::dp_ctl_t       ctl
);

	lmcfd_pkg::step_t              step_q;
	logic [lmcfd_pkg::CNT_W-1:0]   d_q;
	logic [lmcfd_pkg::CNT_W-1:0]   n_q;
	logic [lmcfd_pkg::ROW_W-1:0]   r_q;

	lmcfd_pkg::uword_t             uw;
	lmcfd_pkg::step_t              entry;
	logic [lmcfd_pkg::PROD_W-1:0]  prod;
	logic [lmcfd_pkg::CNT_W-1:0]   n_now;
	logic                          emits;
	logic                          go;
	logic                          d_last;
	logic                          r_last;

	// Fetch the control word and evaluate branch conditions
	always_comb begin
		uw     = lmcfd_pkg::ucode_rom(step_q);
		entry  = lmcfd_pkg::dispatch(req.cmd);
		prod   = {4'd0, cfg.tiles_wide} * {4'd0, cfg.tiles_high};
		n_now  = (prod > lmcfd_pkg::MAX_DISP_PROD) ? lmcfd_pkg::MAX_DISP_CNT
			: prod[lmcfd_pkg::CNT_W-1:0];
		emits  = (req.cmd == lmcfd_pkg::CMD_SHOW) || (req.cmd == lmcfd_pkg::CMD_START)
			|| (req.cmd == lmcfd_pkg::CMD_BRIGHT);
		go     = start && (entry != lmcfd_pkg::ST_IDLE)
			&& !(emits && (n_now == '0))
			&& !((req.cmd == lmcfd_pkg::CMD_BRIGHT) && (|req.brightness[7:4]));
		d_last = (d_q == lmcfd_pkg::CNT_W'(1));
		r_last = (r_q == lmcfd_pkg::ROW_LAST);
	end

	assign busy = (step_q != lmcfd_pkg::ST_IDLE);

	// Advance the step counter and the module and row loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lmcfd_pkg::ST_IDLE;
			d_q    <= '0;
			n_q    <= '0;
			r_q    <= '0;
		end else begin
			unique case (uw.cond)
				lmcfd_pkg::CN_DISPATCH: begin
					if (go) begin
						step_q <= entry;
						d_q    <= n_now;
						n_q    <= n_now;
						r_q    <= '0;
					end
				end
				lmcfd_pkg::CN_NEXT: begin
					step_q <= uw.next;
				end
				lmcfd_pkg::CN_LOOP_D: begin
					if (!d_last) begin
						d_q <= d_q - lmcfd_pkg::CNT_W'(1);
					end else begin
						d_q    <= n_q;
						step_q <= uw.next;
					end
				end
				lmcfd_pkg::CN_LOOP_DR: begin
					if (!d_last) begin
						d_q <= d_q - lmcfd_pkg::CNT_W'(1);
					end else if (!r_last) begin
						d_q <= n_q;
						r_q <= r_q + lmcfd_pkg::ROW_W'(1);
					end else begin
						step_q <= uw.next;
					end
				end
			endcase
		end
	end

	// Drive the datapath from the current control word
	always_comb begin
		ctl.op         = uw.op;
		ctl.word_cmd   = (uw.op == lmcfd_pkg::OP_EMIT_MEM) ? (uw.word_cmd + {1'b0, r_q})
			: uw.word_cmd;
		ctl.word_data  = uw.word_data;
		ctl.use_bright = uw.use_bright;
		ctl.frame_end  = d_last;
		ctl.last       = d_last && uw.last_frame
			&& (r_last || (uw.cond != lmcfd_pkg::CN_LOOP_DR));
		ctl.row        = r_q;
		ctl.mod_idx    = lmcfd_pkg::MOD_W'(d_q - lmcfd_pkg::CNT_W'(1));
	end

	`LMCFD_ASSERT_IMP(a_emit_in_range, (ctl.op == lmcfd_pkg::OP_EMIT_MEM || ctl.op == lmcfd_pkg::OP_EMIT_CONST), (d_q != '0 && d_q <= n_q), "module counter out of range while emitting")
	`LMCFD_ASSERT_IMP(a_row_after_frame, ($past(step_q) == lmcfd_pkg::ST_SHOW && step_q == lmcfd_pkg::ST_SHOW && !$stable(r_q)), ($past(d_q) == lmcfd_pkg::CNT_W'(1)), "row advanced before the frame ended")

endmodule

`default_nettype wire

@@ design/lmcfd_dp.sv @@
`default_nettype none
`include "led_matrix_chain_frame_driver_macros.svh"

module lmcfd_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire lmcfd_pkg::req_t     req,
	input  wire lmcfd_pkg::cfg_t     cfg,
	input  wire lmcfd_pkg::dp_ctl_t  ctl,
	output logic                     res_strobe,
	output lmcfd_pkg::res_t          res
);

	lmcfd_pkg::req_t                    item_q;
	logic [7:0]                         mem_q [lmcfd_pkg::MEM_DEPTH];
	logic [lmcfd_pkg::MEM_DEPTH-1:0]    valid_q;

	logic [7:0]                         rdata_s1;
	logic                               rvalid_s1;
	logic                               strobe_s1;
	logic                               from_mem_s1;
	logic [3:0]                         cmd_s1;
	logic [7:0]                         data_s1;
	logic                               fend_s1;
	logic                               last_s1;

	logic [lmcfd_pkg::TILE_W-1:0]       tile;
	logic                               tile_ok;
	logic [lmcfd_pkg::ADDR_W-1:0]       pix_addr;
	logic [4:0]                         map_lsb;
	logic [lmcfd_pkg::MOD_W-1:0]        phys;
	logic [lmcfd_pkg::ADDR_W-1:0]       row_addr;
	logic [lmcfd_pkg::ADDR_W-1:0]       rd_addr;
	logic [7:0]                         old_byte;
	logic [7:0]                         bit_mask;
	logic [7:0]                         pix_byte;
	logic                               wr_en;
	logic [lmcfd_pkg::ADDR_W-1:0]       wr_addr;
	logic [7:0]                         wr_data;
	logic                               emit;

	// Address and data for pixel and row updates
	always_comb begin
		tile     = {4'd0, item_q.x[5:3]}
			+ ({4'd0, item_q.y[5:3]} * {3'd0, cfg.tiles_wide});
		tile_ok  = (tile < lmcfd_pkg::MAX_DISP_TILE);
		pix_addr = {tile[lmcfd_pkg::MOD_W-1:0], item_q.y[2:0]};
		map_lsb  = {1'b0, item_q.display_slot, 1'b0} + {2'b00, item_q.display_slot};
		phys     = cfg.display_map[map_lsb +: lmcfd_pkg::MOD_W];
		row_addr = {phys, item_q.row};
		rd_addr  = (ctl.op == lmcfd_pkg::OP_PIX_RD) ? pix_addr : {ctl.mod_idx, ctl.row};
		old_byte = rvalid_s1 ? rdata_s1 : 8'd0;
		bit_mask = 8'd1 << item_q.x[2:0];
		pix_byte = item_q.pixel_on ? (old_byte | bit_mask) : (old_byte & ~bit_mask);
		wr_en    = ((ctl.op == lmcfd_pkg::OP_PIX_WR) && tile_ok)
			|| (ctl.op == lmcfd_pkg::OP_ROW_WR);
		wr_addr  = (ctl.op == lmcfd_pkg::OP_PIX_WR) ? pix_addr : row_addr;
		wr_data  = (ctl.op == lmcfd_pkg::OP_PIX_WR) ? pix_byte : item_q.row_bits;
		emit     = (ctl.op == lmcfd_pkg::OP_EMIT_MEM) || (ctl.op == lmcfd_pkg::OP_EMIT_CONST);
	end

	// Hold the request; frame store and word stage
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rdata_s1    <= mem_q[rd_addr];
		from_mem_s1 <= (ctl.op == lmcfd_pkg::OP_EMIT_MEM);
		cmd_s1      <= ctl.word_cmd;
		data_s1     <= ctl.use_bright ? item_q.brightness : ctl.word_data;
		fend_s1     <= ctl.frame_end;
		last_s1     <= ctl.last;
	end

	// Entry valid bits read as zero until first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
			strobe_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rvalid_s1 <= valid_q[rd_addr];
			strobe_s1 <= emit;
		end
	end

	assign res_strobe    = strobe_s1;
	assign res.word_cmd  = cmd_s1;
	assign res.word_data = from_mem_s1 ? (rvalid_s1 ? rdata_s1 : 8'd0) : data_s1;
	assign res.frame_end = fend_s1;
	assign res.last      = last_s1;

	`LMCFD_ASSERT_IMP(a_pix_read_first, (ctl.op == lmcfd_pkg::OP_PIX_WR), ($past(ctl.op) == lmcfd_pkg::OP_PIX_RD), "pixel write without preceding read")
	`LMCFD_ASSERT_IMP(a_last_ends_frame, (res_strobe && res.last), res.frame_end, "final word does not close a frame")

endmodule

`default_nettype wire

@@ design/led_matrix_chain_frame_driver.sv @@
// The first word of show, start or intensity passes the step register and then the word
// stage register after accept. Throughput: words go out one per cycle; show sends 8n words,
// start 5n and the intensity command n (n = module count, max 8), one word per step of the
// control store frame loops; set_pixel reads then writes the store, write_row only writes it.
// The receiver cannot stall; each word is shown for exactly one cycle on res_strobe.
// Reset clears the frame store at once through per-entry valid bits and loads the defaults.
`default_nettype none

module led_matrix_chain_frame_driver (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire lmcfd_pkg::req_t               req,
	output logic                               res_strobe,
	output lmcfd_pkg::res_t                    res,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lmcfd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);

	lmcfd_pkg::cfg_t    cfg;
	lmcfd_pkg::dp_ctl_t ctl;
	logic               accept;

	// Take a request only while the sequencer is idle
	assign accept = start && !busy;

	lmcfd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lmcfd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.cfg    (cfg),
		.busy   (busy),
		.ctl    (ctl)
	);

	lmcfd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req        (req),
		.cfg        (cfg),
		.ctl        (ctl),
		.res_strobe (res_strobe),
		.res        (res)
	);

endmodule

`default_nettype wire
